>>> rtl/core/paf_pkg.sv
package paf_pkg;

    // Number of attractors with a mode field and an amount register
    localparam int NUM_ATTR = 4;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_RANGE   = 3'd0,
        REG_MODES   = 3'd1,
        REG_AMOUNT0 = 3'd2,
        REG_AMOUNT1 = 3'd3,
        REG_AMOUNT2 = 3'd4,
        REG_AMOUNT3 = 3'd5
    } cfg_reg_t;

    // Attractor mode codes; every other code adds nothing
    localparam logic [1:0] MODE_ATTRACT = 2'd1;
    localparam logic [1:0] MODE_REPULSE = 2'd2;

    // Reset values of the configuration registers
    localparam logic [30:0] RANGE_RESET  = 31'd3276800;
    localparam logic [31:0] AMOUNT_RESET = 32'd65536;

    // Smallest length used for the coefficient, 0.05 in Q16.16
    localparam logic [34:0] MIN_LEN = 35'd3277;
    localparam logic [35:0] ONE_Q16 = 36'd65536;

    // Clamp on one contribution's magnitude
    localparam logic [55:0] TERM_MAX = 56'h0000_0100_0000_0000;

    // Step counts of the serial operations, minus one
    localparam logic [5:0] SQ_STEPS  = 6'd30;
    localparam logic [5:0] RT_STEPS  = 6'd31;
    localparam logic [5:0] UD_STEPS  = 6'd17;
    localparam logic [5:0] QD_STEPS  = 6'd35;
    localparam logic [5:0] F_STEPS   = 6'd17;
    localparam logic [5:0] G_STEPS   = 6'd31;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_LOAD,
        ST_SQ_RUN,
        ST_RT_LOAD,
        ST_RT_RUN,
        ST_LEN,
        ST_UD_LOAD,
        ST_UD_RUN,
        ST_QD_LOAD,
        ST_QD_RUN,
        ST_F_LOAD,
        ST_F_RUN,
        ST_G_LOAD,
        ST_G_RUN,
        ST_ACC,
        ST_DONE
    } state_t;

endpackage

>>> rtl/core/particle_attraction_force_unit.sv
// Attraction force accumulator. Each input item carries a particle position and one
// attractor's target point (Q16.16); the block adds that attractor's pull or push to
// three running sums and, on the item marked tlast, returns the sums saturated to
// 32 bits and clears them. All arithmetic runs one bit per cycle through a shared
// shift-add / shift-subtract unit. An item of mode none adds nothing; an active item
// runs three 31-step squarings, a 32-step square root, three 18-step direction divides
// (skipped at zero distance), a 36-step range divide, then per axis an 18-step and a
// 32-step multiply, each operation preceded by a load state. The next item is taken as
// soon as the block returns to idle; a finished result waits in the output register
// and only stalls the block if a second result is ready before the first is taken.
// Configuration is written through cfg_wr_en, cfg_addr and cfg_wdata; the user must
// write it only while the block is idle, as the block itself does not enforce this.
module particle_attraction_force_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // particle_x, particle_y, particle_z, target_x, target_y, target_z
    input  logic [191:0] s_tdata,
    // attractor
    input  logic [1:0]   s_tuser,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // accel_delta_x, accel_delta_y, accel_delta_z
    output logic [95:0]  m_tdata,
    // saturated
    output logic         m_tuser,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata
);
    import paf_pkg::*;

    state_t state_reg, state_next;

    logic [5:0]         cnt_reg;
    logic [1:0]         axis_reg;
    logic [1:0]         axis_inc;
    logic [71:0]        acc_reg;
    logic [71:0]        sh_reg;
    logic [63:0]        qr_reg;
    logic [32:0]        mag_reg [3];
    logic [2:0]         neg_reg;
    logic               wide_reg;
    logic [17:0]        u_reg [3];
    logic [34:0]        len_reg;
    logic [35:0]        c_reg;
    logic               repulse_reg;
    logic               last_reg;
    logic [31:0]        amag_reg;
    logic               aneg_reg;
    logic signed [39:0] sum_reg [3];

    logic [30:0]        range_reg;
    logic [7:0]         modes_reg;
    logic [31:0]        amount_reg [NUM_ATTR];

    logic               m_tvalid_reg;
    logic [95:0]        m_tdata_reg;
    logic               m_tuser_reg;

    // Input decode
    logic [32:0] in_diff [3];
    logic [32:0] in_mag [3];
    logic        in_wide;
    logic [1:0]  sel_mode;
    logic        in_active;
    logic [31:0] sel_amount;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_diff[i] = {s_tdata[96 + 32*i + 31], s_tdata[96 + 32*i +: 32]}
                       - {s_tdata[32*i + 31], s_tdata[32*i +: 32]};
            in_mag[i]  = in_diff[i][32] ? (33'd0 - in_diff[i]) : in_diff[i];
        end
        in_wide    = |in_mag[0][32:31] | |in_mag[1][32:31] | |in_mag[2][32:31];
        sel_mode   = modes_reg[{s_tuser, 1'b0} +: 2];
        in_active  = (sel_mode == MODE_ATTRACT) || (sel_mode == MODE_REPULSE);
        sel_amount = amount_reg[s_tuser];
    end

    // Serial arithmetic unit
    logic [30:0] sq_t;
    logic [71:0] mul_sum;
    logic        div_ge;
    logic [71:0] div_diff;
    logic [63:0] div_q;
    logic [63:0] rt_trial;
    logic        rt_ge;
    logic        cnt_done;
    logic [34:0] len_calc;
    logic [34:0] len_eff;
    logic [35:0] c_calc;
    logic [40:0] g_mag;
    logic        g_neg;
    logic signed [41:0] term;
    logic signed [41:0] acc_sum;
    logic signed [39:0] sum_sat;

    always_comb begin
        sq_t     = wide_reg ? mag_reg[axis_reg][32:2] : mag_reg[axis_reg][30:0];
        mul_sum  = acc_reg + sh_reg;
        div_ge   = acc_reg >= sh_reg;
        div_diff = acc_reg - sh_reg;
        div_q    = {qr_reg[62:0], div_ge};
        rt_trial = qr_reg + sh_reg[63:0];
        rt_ge    = acc_reg[63:0] >= rt_trial;
        cnt_done = cnt_reg == 6'd0;
        axis_inc = (axis_reg == 2'd2) ? 2'd0 : axis_reg + 2'd1;
        len_calc = wide_reg ? {qr_reg[32:0], 2'b00} : {2'b00, qr_reg[32:0]};
        len_eff  = (len_reg < MIN_LEN) ? MIN_LEN : len_reg;
        c_calc   = (div_q[35:0] > ONE_Q16) ? (div_q[35:0] - ONE_Q16) : 36'd0;
        g_mag    = (acc_reg[71:16] > TERM_MAX) ? TERM_MAX[40:0] : acc_reg[56:16];
        g_neg    = neg_reg[axis_reg] ^ aneg_reg ^ repulse_reg;
        term     = g_neg ? -$signed({1'b0, g_mag}) : $signed({1'b0, g_mag});
        acc_sum  = {{2{sum_reg[axis_reg][39]}}, sum_reg[axis_reg]} + term;
        if (acc_sum > 42'sd549755813887) begin
            sum_sat = 40'sh7F_FFFF_FFFF;
        end else if (acc_sum < -42'sd549755813888) begin
            sum_sat = 40'sh80_0000_0000;
        end else begin
            sum_sat = acc_sum[39:0];
        end
    end

    // Output saturation
    logic [95:0] out_data;
    logic        out_flag;

    always_comb begin
        out_flag = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (!sum_reg[i][39] && |sum_reg[i][38:31]) begin
                out_data[32*i +: 32] = 32'h7FFF_FFFF;
                out_flag             = 1'b1;
            end else if (sum_reg[i][39] && !(&sum_reg[i][38:31])) begin
                out_data[32*i +: 32] = 32'h8000_0000;
                out_flag             = 1'b1;
            end else begin
                out_data[32*i +: 32] = sum_reg[i][31:0];
            end
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = in_active ? ST_SQ_LOAD : ST_DONE;
                end
            end
            ST_SQ_LOAD: state_next = ST_SQ_RUN;
            ST_SQ_RUN: begin
                if (cnt_done) begin
                    state_next = (axis_reg == 2'd2) ? ST_RT_LOAD : ST_SQ_LOAD;
                end
            end
            ST_RT_LOAD: state_next = ST_RT_RUN;
            ST_RT_RUN: begin
                if (cnt_done) begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN: state_next = (len_calc == 35'd0) ? ST_QD_LOAD : ST_UD_LOAD;
            ST_UD_LOAD: state_next = ST_UD_RUN;
            ST_UD_RUN: begin
                if (cnt_done) begin
                    state_next = (axis_reg == 2'd2) ? ST_QD_LOAD : ST_UD_LOAD;
                end
            end
            ST_QD_LOAD: state_next = ST_QD_RUN;
            ST_QD_RUN: begin
                if (cnt_done) begin
                    state_next = ST_F_LOAD;
                end
            end
            ST_F_LOAD: state_next = ST_F_RUN;
            ST_F_RUN: begin
                if (cnt_done) begin
                    state_next = ST_G_LOAD;
                end
            end
            ST_G_LOAD: state_next = ST_G_RUN;
            ST_G_RUN: begin
                if (cnt_done) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: state_next = (axis_reg == 2'd2) ? ST_DONE : ST_F_LOAD;
            ST_DONE: begin
                if (!last_reg || !m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    logic out_load;

    always_comb begin
        s_tready = state_reg == ST_IDLE;
        out_load = (state_reg == ST_DONE) && last_reg && (!m_tvalid_reg || m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath sequencing
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    for (int i = 0; i < 3; i++) begin
                        mag_reg[i] <= in_mag[i];
                        neg_reg[i] <= in_diff[i][32];
                    end
                    wide_reg    <= in_wide;
                    last_reg    <= s_tlast;
                    repulse_reg <= sel_mode == MODE_REPULSE;
                    aneg_reg    <= sel_amount[31];
                    amag_reg    <= sel_amount[31] ? (32'd0 - sel_amount) : sel_amount;
                    acc_reg     <= 72'd0;
                    axis_reg    <= 2'd0;
                end
            end
            ST_SQ_LOAD: begin
                sh_reg  <= {41'd0, sq_t};
                qr_reg  <= {33'd0, sq_t};
                cnt_reg <= SQ_STEPS;
            end
            ST_RT_LOAD: begin
                qr_reg  <= 64'd0;
                sh_reg  <= {9'd0, 1'b1, 62'd0};
                cnt_reg <= RT_STEPS;
            end
            ST_RT_RUN: begin
                if (rt_ge) begin
                    acc_reg <= {8'd0, acc_reg[63:0] - rt_trial};
                    qr_reg  <= {1'b0, qr_reg[63:1]} + sh_reg[63:0];
                end else begin
                    qr_reg  <= {1'b0, qr_reg[63:1]};
                end
                sh_reg  <= {2'd0, sh_reg[71:2]};
                cnt_reg <= cnt_reg - 6'd1;
            end
            ST_LEN: begin
                len_reg <= len_calc;
                if (len_calc == 35'd0) begin
                    u_reg[0] <= 18'd0;
                    u_reg[1] <= 18'd0;
                    u_reg[2] <= ONE_Q16[17:0];
                    neg_reg  <= 3'b000;
                end
            end
            ST_UD_LOAD: begin
                acc_reg <= {23'd0, mag_reg[axis_reg], 16'd0};
                sh_reg  <= {20'd0, len_reg, 17'd0};
                qr_reg  <= 64'd0;
                cnt_reg <= UD_STEPS;
            end
            ST_QD_LOAD: begin
                acc_reg <= {25'd0, range_reg, 16'd0};
                sh_reg  <= {2'd0, len_eff, 35'd0};
                qr_reg  <= 64'd0;
                cnt_reg <= QD_STEPS;
            end
            ST_UD_RUN, ST_QD_RUN: begin
                if (div_ge) begin
                    acc_reg <= div_diff;
                end
                qr_reg  <= div_q;
                sh_reg  <= {1'b0, sh_reg[71:1]};
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_done) begin
                    if (state_reg == ST_UD_RUN) begin
                        u_reg[axis_reg] <= div_q[17:0];
                        axis_reg        <= axis_inc;
                    end else begin
                        c_reg <= c_calc;
                    end
                end
            end
            ST_F_LOAD: begin
                acc_reg <= 72'd0;
                sh_reg  <= {36'd0, c_reg};
                qr_reg  <= {46'd0, u_reg[axis_reg]};
                cnt_reg <= F_STEPS;
            end
            ST_G_LOAD: begin
                acc_reg <= 72'd0;
                sh_reg  <= {16'd0, acc_reg[71:16]};
                qr_reg  <= {32'd0, amag_reg};
                cnt_reg <= G_STEPS;
            end
            ST_SQ_RUN, ST_F_RUN, ST_G_RUN: begin
                if (qr_reg[0]) begin
                    acc_reg <= mul_sum;
                end
                sh_reg  <= {sh_reg[70:0], 1'b0};
                qr_reg  <= {1'b0, qr_reg[63:1]};
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_done && state_reg == ST_SQ_RUN) begin
                    axis_reg <= axis_inc;
                end
            end
            // Advance to the next axis once its contribution is summed
            ST_ACC: axis_reg <= axis_inc;
            default: ;
        endcase
    end

    // Running sums: add each contribution, clear once a result is issued
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                sum_reg[i] <= 40'sd0;
            end
        end else if (out_load) begin
            for (int i = 0; i < 3; i++) begin
                sum_reg[i] <= 40'sd0;
            end
        end else if (state_reg == ST_ACC) begin
            sum_reg[axis_reg] <= sum_sat;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= out_data;
            m_tuser_reg <= out_flag;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_reg <= RANGE_RESET;
            modes_reg <= 8'd0;
            for (int i = 0; i < NUM_ATTR; i++) begin
                amount_reg[i] <= AMOUNT_RESET;
            end
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                REG_RANGE:   range_reg     <= cfg_wdata[30:0];
                REG_MODES:   modes_reg     <= cfg_wdata[7:0];
                REG_AMOUNT0: amount_reg[0] <= cfg_wdata;
                REG_AMOUNT1: amount_reg[1] <= cfg_wdata;
                REG_AMOUNT2: amount_reg[2] <= cfg_wdata;
                REG_AMOUNT3: amount_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/core/paf_checker.sv
module paf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic        m_tuser
);

    // No result right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Hold a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Go busy once an item is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready held after accepting an item");

    // Clipped flag implies some component at a limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |->
            m_tdata[31:0] == 32'h7FFF_FFFF || m_tdata[31:0] == 32'h8000_0000 ||
            m_tdata[63:32] == 32'h7FFF_FFFF || m_tdata[63:32] == 32'h8000_0000 ||
            m_tdata[95:64] == 32'h7FFF_FFFF || m_tdata[95:64] == 32'h8000_0000)
        else $error("saturated flag without a clipped component");

endmodule

bind particle_attraction_force_unit paf_checker u_paf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
